### src/sbam_pkg.sv
// ----------------------------------------------------------------------------
// sbam_pkg
// Types and constants for the serial bus access manager: item codes,
// management command numbers, mode bits and transceiver enable patterns.
// ----------------------------------------------------------------------------
package sbam_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_RX_BYTE = 2'd1,
      OP_COMMAND = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   // management commands
   typedef enum logic [2:0] {
      CMD_READ_OWN      = 3'd0,
      CMD_SET_OWN       = 3'd1,
      CMD_READ_CONNECT  = 3'd2,
      CMD_SET_CONNECT   = 3'd3,
      CMD_READ_SHUTDOWN = 3'd4,
      CMD_START_SHUT    = 3'd5,
      CMD_READ_STATUS   = 3'd6,
      CMD_SET_STATUS    = 3'd7
   } cmd_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_LOCKOUT_TIME     = 3'd0,
      CSR_BOOTLOAD_TIME    = 3'd1,
      CSR_ECHO_TIMEOUT     = 3'd2,
      CSR_SHUTDOWN_TIME    = 3'd3,
      CSR_RESET_PULSE_TIME = 3'd4,
      CSR_DEFAULT_OWN      = 3'd5,
      CSR_DEFAULT_CONNECT  = 3'd6,
      CSR_LOCKOUT_AT_RESET = 3'd7
   } csr_index_type;

   localparam int LONG_W  = 17;
   localparam int SHORT_W = 12;
   localparam int PULSE_W = 8;
   localparam int ADDR_W  = 7;

   // mode_flags bit positions
   localparam int MODE_BOOT_BIT = 0;
   localparam int MODE_LOCK_BIT = 1;
   localparam int MODE_HOST_BIT = 2;

   // shutdown_state bit positions
   localparam int SD_STARTED_BIT = 0;
   localparam int SD_SEEN_BIT    = 1;

   // status bit positions
   localparam int ST_ECHO_TIMEOUT  = 0;
   localparam int ST_ECHO_MISMATCH = 2;
   localparam int ST_HOST_LOCKOUT  = 3;

   // enable patterns: bit0 rx driver, bit1 rx rcv off, bit2 tx driver, bit3 tx rcv off
   localparam logic [3:0] PAT_NORMAL_LOCAL   = 4'h5;
   localparam logic [3:0] PAT_NORMAL_FOREIGN = 4'h8;
   localparam logic [3:0] PAT_NORMAL_BASE    = 4'h1;
   localparam logic [3:0] PAT_AWARE          = 4'h4;
   localparam logic [3:0] PAT_BOOT_LOCAL     = 4'h5;
   localparam logic [3:0] PAT_BOOT_FOREIGN   = 4'hC;
   localparam logic [3:0] PAT_LOCK_LOCAL     = 4'h3;
   localparam logic [3:0] PAT_LOCK_FOREIGN   = 4'hA;
   localparam logic [3:0] PAT_DISCONNECT     = 4'hA;

   // register defaults
   localparam logic [LONG_W-1:0]  LOCKOUT_TIME_RST  = 17'd120000;
   localparam logic [LONG_W-1:0]  BOOTLOAD_TIME_RST = 17'd115000;
   localparam logic [SHORT_W-1:0] ECHO_TIMEOUT_RST  = 12'd500;
   localparam logic [SHORT_W-1:0] SHUTDOWN_TIME_RST = 12'd1000;
   localparam logic [PULSE_W-1:0] RESET_PULSE_RST   = 8'd20;
   localparam logic [ADDR_W-1:0]  OWN_ADDR_RST      = 7'd49;
   localparam logic [ADDR_W-1:0]  CONNECT_ADDR_RST  = 7'd48;
   localparam logic               LOCKOUT_AT_RST    = 1'b0;

   // one request item
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic [2:0] command_code;
      logic [7:0] command_data;
      logic       command_has_data;
      logic       host_request;
      logic       shutdown_pin_low;
   } req_type;

   // one result item
   typedef struct packed {
      logic [3:0] enables;
      logic       send_valid;
      logic [7:0] send_byte;
      logic [7:0] reply_data;
      logic [7:0] status_bits;
      logic       mcu_reset_low;
      logic       host_clear;
      logic       shutdown_drive;
      logic       shutdown_seen;
   } rsp_type;

endpackage

### src/serial_bus_access_manager.sv
// ----------------------------------------------------------------------------
// serial_bus_access_manager
// Bus access manager for a multidrop serial bus with a shared control pair.
//
// Usage: each request item is a millisecond tick (with host request and
// shutdown pin samples), a byte received on the control pair, or a
// management command write. Every item yields exactly one result item with
// the transceiver enables, an optional byte to send, the command reply,
// status and the reset / host / shutdown lines.
// Both channels use valid/stall; an item moves when valid is high and stall
// low. The request is captured in an input register, processed by one pass
// of logic into the result register, which then raises rsp_valid, and one
// item is taken every cycle while rsp_stall is low.
// A stalled result holds in the result register; the input register keeps
// accepting until it is full, then req_stall rises.
// Reset (synchronous, active high) restores all non-payload registers to
// their defaults, idles both channels and loads the mode state from those
// defaults. Write configuration on csr_* only while idle (not enforced);
// the default own address and lockout-at-reset registers only matter at
// reset, which restores their defaults, so they are accepted but not stored.
// ----------------------------------------------------------------------------
module serial_bus_access_manager (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_rx_byte,
   input  logic [2:0] req_command_code,
   input  logic [7:0] req_command_data,
   input  logic       req_command_has_data,
   input  logic       req_host_request,
   input  logic       req_shutdown_pin_low,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_rx_driver_en,
   output logic       rsp_rx_receiver_off,
   output logic       rsp_tx_driver_en,
   output logic       rsp_tx_receiver_off,
   output logic       rsp_send_valid,
   output logic [7:0] rsp_send_byte,
   output logic [7:0] rsp_reply_data,
   output logic [7:0] rsp_status_bits,
   output logic       rsp_mcu_reset_low,
   output logic       rsp_host_clear,
   output logic       rsp_shutdown_drive,
   output logic       rsp_shutdown_seen,
   // configuration
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);
   import sbam_pkg::*;

   // configuration registers
   logic [LONG_W-1:0]  lockout_time_ff;
   logic [LONG_W-1:0]  bootload_time_ff;
   logic [SHORT_W-1:0] echo_timeout_ff;
   logic [SHORT_W-1:0] shutdown_time_ff;
   logic [PULSE_W-1:0] reset_pulse_ff;
   logic [ADDR_W-1:0]  dflt_connect_ff;

   // pipeline registers
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    advance, process, accept;

   // block state
   logic [2:0]         mode_ff, mode_in;
   logic               foreign_ff, foreign_in;
   logic               aware_ff, aware_in;
   logic               host_on_ff, host_on_in;
   logic               echo_pend_ff, echo_pend_in;
   logic [7:0]         last_sent_ff, last_sent_in;
   logic [SHORT_W-1:0] echo_tmr_ff, echo_tmr_in;
   logic [LONG_W-1:0]  lock_tmr_ff, lock_tmr_in;
   logic [LONG_W-1:0]  boot_tmr_ff, boot_tmr_in;
   logic [7:0]         own_addr_ff, own_addr_in;
   logic [7:0]         conn_addr_ff, conn_addr_in;
   logic [7:0]         status_ff, status_in;
   logic [1:0]         sd_ff, sd_in;
   logic [SHORT_W-1:0] sd_tmr_ff, sd_tmr_in;
   logic [PULSE_W-1:0] rst_tmr_ff, rst_tmr_in;
   logic               cts_ff, cts_in;
   logic [3:0]         pat_ff, pat_in;

   logic       sent_now;
   logic       send_v;
   logic [7:0] send_b;
   logic [7:0] reply;

   // enable pattern when returning to normal mode
   function automatic logic [3:0] normal_pattern(input logic foreign, input logic aware);
      logic [3:0] p;
      p = foreign ? PAT_NORMAL_FOREIGN : PAT_NORMAL_BASE;
      if (aware) p = p | PAT_AWARE;
      return p;
   endfunction

   // handshake: results leave the output register, new items enter the input one
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) in_valid_in = 1'b1;
      else if (process) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (process) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_time_ff  <= LOCKOUT_TIME_RST;
         bootload_time_ff <= BOOTLOAD_TIME_RST;
         echo_timeout_ff  <= ECHO_TIMEOUT_RST;
         shutdown_time_ff <= SHUTDOWN_TIME_RST;
         reset_pulse_ff   <= RESET_PULSE_RST;
         dflt_connect_ff  <= CONNECT_ADDR_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_LOCKOUT_TIME:     lockout_time_ff  <= csr_data[LONG_W-1:0];
            CSR_BOOTLOAD_TIME:    bootload_time_ff <= csr_data[LONG_W-1:0];
            CSR_ECHO_TIMEOUT:     echo_timeout_ff  <= csr_data[SHORT_W-1:0];
            CSR_SHUTDOWN_TIME:    shutdown_time_ff <= csr_data[SHORT_W-1:0];
            CSR_RESET_PULSE_TIME: reset_pulse_ff   <= csr_data[PULSE_W-1:0];
            CSR_DEFAULT_CONNECT:  dflt_connect_ff  <= csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // one pass over the item in the input register
   always_comb begin
      mode_in      = mode_ff;
      foreign_in   = foreign_ff;
      aware_in     = aware_ff;
      host_on_in   = host_on_ff;
      echo_pend_in = echo_pend_ff;
      last_sent_in = last_sent_ff;
      echo_tmr_in  = echo_tmr_ff;
      lock_tmr_in  = lock_tmr_ff;
      boot_tmr_in  = boot_tmr_ff;
      own_addr_in  = own_addr_ff;
      conn_addr_in = conn_addr_ff;
      status_in    = status_ff;
      sd_in        = sd_ff;
      sd_tmr_in    = sd_tmr_ff;
      rst_tmr_in   = rst_tmr_ff;
      cts_in       = cts_ff;
      pat_in       = pat_ff;
      sent_now     = 1'b0;
      send_v       = 1'b0;
      send_b       = 8'd0;
      reply        = 8'd0;

      case (op_type'(in_ff.op))
         OP_TICK: begin
            // bootload timeout
            if (mode_in[MODE_BOOT_BIT]) begin
               if (boot_tmr_in >= bootload_time_ff) begin
                  pat_in = normal_pattern(foreign_in, aware_in);
                  mode_in[MODE_HOST_BIT] = 1'b1;
                  mode_in[MODE_BOOT_BIT] = 1'b0;
               end else begin
                  boot_tmr_in = boot_tmr_in + 1'b1;
               end
            end
            // local host connect / disconnect
            if (!foreign_in) begin
               if (in_ff.host_request) begin
                  if (!status_in[ST_HOST_LOCKOUT]) begin
                     if (!cts_in) begin
                        cts_in = 1'b1;
                     end else if (mode_in == 3'd0 && !echo_pend_in) begin
                        sent_now     = 1'b1;
                        send_b       = conn_addr_in;
                        last_sent_in = conn_addr_in;
                        echo_tmr_in  = '0;
                        echo_pend_in = 1'b1;
                        host_on_in   = 1'b1;
                     end
                  end
               end else if (mode_in[MODE_HOST_BIT] && host_on_in && !echo_pend_in &&
                            !mode_in[MODE_BOOT_BIT] && !mode_in[MODE_LOCK_BIT]) begin
                  sent_now     = 1'b1;
                  send_b       = {1'b1, ~dflt_connect_ff};
                  last_sent_in = {1'b1, ~dflt_connect_ff};
                  echo_tmr_in  = '0;
                  echo_pend_in = 1'b1;
                  host_on_in   = 1'b0;
                  cts_in       = 1'b0;
               end
            end
            send_v = sent_now;
            // lockout timeout
            if (mode_in[MODE_LOCK_BIT]) begin
               if (lock_tmr_in >= lockout_time_ff) begin
                  pat_in = normal_pattern(foreign_in, aware_in);
                  mode_in[MODE_HOST_BIT] = 1'b1;
                  mode_in[MODE_LOCK_BIT] = 1'b0;
               end else begin
                  lock_tmr_in = lock_tmr_in + 1'b1;
               end
            end
            // echo wait
            if (echo_pend_in && !sent_now) begin
               if (echo_tmr_in >= echo_timeout_ff) begin
                  status_in[ST_ECHO_TIMEOUT] = 1'b1;
                  echo_pend_in = 1'b0;
               end else begin
                  echo_tmr_in = echo_tmr_in + 1'b1;
               end
            end
            // shutdown handshake
            if (sd_in[SD_STARTED_BIT]) begin
               if (sd_tmr_in >= shutdown_time_ff) sd_in = 2'b10;
               else sd_tmr_in = sd_tmr_in + 1'b1;
            end else if (!sd_in[SD_SEEN_BIT] && in_ff.shutdown_pin_low) begin
               sd_in[SD_SEEN_BIT] = 1'b1;
            end
            // local reset pulse
            if (rst_tmr_in != '0) rst_tmr_in = rst_tmr_in - 1'b1;
         end

         OP_RX_BYTE: begin
            // echo check or foreign traffic
            if (echo_pend_in) begin
               if (in_ff.rx_byte != last_sent_in) status_in[ST_ECHO_MISMATCH] = 1'b1;
               echo_pend_in = 1'b0;
               foreign_in   = 1'b0;
            end else begin
               foreign_in = !host_on_in;
            end
            // decode the byte
            if (in_ff.rx_byte == 8'd0) begin
               lock_tmr_in = lockout_time_ff;
               boot_tmr_in = bootload_time_ff;
            end else if (in_ff.rx_byte == own_addr_in) begin
               pat_in = foreign_in ? PAT_BOOT_FOREIGN : PAT_BOOT_LOCAL;
               mode_in[MODE_BOOT_BIT] = 1'b1;
               rst_tmr_in  = reset_pulse_ff;
               aware_in    = 1'b0;
               boot_tmr_in = '0;
            end else if (!in_ff.rx_byte[7]) begin
               mode_in     = 3'b000;
               mode_in[MODE_LOCK_BIT] = 1'b1;
               pat_in      = foreign_in ? PAT_LOCK_FOREIGN : PAT_LOCK_LOCAL;
               lock_tmr_in = '0;
            end else begin
               foreign_in = 1'b0;
               mode_in    = 3'b000;
               pat_in     = PAT_DISCONNECT;
            end
         end

         OP_COMMAND: begin
            if (in_ff.command_has_data) begin
               case (cmd_type'(in_ff.command_code))
                  CMD_READ_OWN: begin
                     aware_in = 1'b1;
                     if (host_on_in) begin
                        send_v       = 1'b1;
                        last_sent_in = 8'd0;
                        echo_tmr_in  = '0;
                        echo_pend_in = 1'b1;
                     end else if (mode_in[MODE_BOOT_BIT]) begin
                        send_v       = 1'b1;
                        last_sent_in = 8'd0;
                        echo_tmr_in  = '0;
                        echo_pend_in = 1'b0;
                     end else begin
                        lock_tmr_in = lockout_time_ff;
                        boot_tmr_in = bootload_time_ff;
                     end
                     reply = own_addr_in;
                  end
                  CMD_SET_OWN: begin
                     own_addr_in = in_ff.command_data;
                     reply       = in_ff.command_data;
                  end
                  CMD_READ_CONNECT: reply = conn_addr_in;
                  CMD_SET_CONNECT: begin
                     conn_addr_in = in_ff.command_data;
                     reply        = in_ff.command_data;
                  end
                  CMD_READ_SHUTDOWN: begin
                     reply = {7'd0, sd_in[SD_SEEN_BIT]};
                     sd_in[SD_SEEN_BIT] = 1'b0;
                  end
                  CMD_START_SHUT: begin
                     if (in_ff.command_data == 8'd1) begin
                        sd_in     = 2'b01;
                        sd_tmr_in = '0;
                     end
                     reply = in_ff.command_data;
                  end
                  CMD_READ_STATUS: reply = status_in;
                  default: begin
                     status_in = in_ff.command_data;
                     reply     = in_ff.command_data;
                  end
               endcase
            end
         end

         default: ;
      endcase

      rsp_in.enables        = pat_in;
      rsp_in.send_valid     = send_v;
      rsp_in.send_byte      = send_b;
      rsp_in.reply_data     = reply;
      rsp_in.status_bits    = status_in;
      rsp_in.mcu_reset_low  = (rst_tmr_in != '0);
      rsp_in.host_clear     = cts_in;
      rsp_in.shutdown_drive = sd_in[SD_STARTED_BIT];
      rsp_in.shutdown_seen  = sd_in[SD_SEEN_BIT];
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 3'd0;
         foreign_ff   <= 1'b0;
         aware_ff     <= 1'b0;
         host_on_ff   <= 1'b0;
         echo_pend_ff <= 1'b0;
         last_sent_ff <= 8'd0;
         echo_tmr_ff  <= '0;
         lock_tmr_ff  <= '0;
         boot_tmr_ff  <= '0;
         own_addr_ff  <= {1'b0, OWN_ADDR_RST};
         conn_addr_ff <= {1'b0, CONNECT_ADDR_RST};
         status_ff    <= {4'd0, LOCKOUT_AT_RST, 3'd0};
         sd_ff        <= 2'd0;
         sd_tmr_ff    <= '0;
         rst_tmr_ff   <= '0;
         cts_ff       <= 1'b0;
         pat_ff       <= PAT_NORMAL_LOCAL;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            mode_ff      <= mode_in;
            foreign_ff   <= foreign_in;
            aware_ff     <= aware_in;
            host_on_ff   <= host_on_in;
            echo_pend_ff <= echo_pend_in;
            last_sent_ff <= last_sent_in;
            echo_tmr_ff  <= echo_tmr_in;
            lock_tmr_ff  <= lock_tmr_in;
            boot_tmr_ff  <= boot_tmr_in;
            own_addr_ff  <= own_addr_in;
            conn_addr_ff <= conn_addr_in;
            status_ff    <= status_in;
            sd_ff        <= sd_in;
            sd_tmr_ff    <= sd_tmr_in;
            rst_tmr_ff   <= rst_tmr_in;
            cts_ff       <= cts_in;
            pat_ff       <= pat_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.op               <= req_op;
         in_ff.rx_byte          <= req_rx_byte;
         in_ff.command_code     <= req_command_code;
         in_ff.command_data     <= req_command_data;
         in_ff.command_has_data <= req_command_has_data;
         in_ff.host_request     <= req_host_request;
         in_ff.shutdown_pin_low <= req_shutdown_pin_low;
      end
      if (process) rsp_ff <= rsp_in;
   end

   // result ports
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rx_driver_en    = rsp_ff.enables[0];
   assign rsp_rx_receiver_off = rsp_ff.enables[1];
   assign rsp_tx_driver_en    = rsp_ff.enables[2];
   assign rsp_tx_receiver_off = rsp_ff.enables[3];
   assign rsp_send_valid      = rsp_ff.send_valid;
   assign rsp_send_byte       = rsp_ff.send_byte;
   assign rsp_reply_data      = rsp_ff.reply_data;
   assign rsp_status_bits     = rsp_ff.status_bits;
   assign rsp_mcu_reset_low   = rsp_ff.mcu_reset_low;
   assign rsp_host_clear      = rsp_ff.host_clear;
   assign rsp_shutdown_drive  = rsp_ff.shutdown_drive;
   assign rsp_shutdown_seen   = rsp_ff.shutdown_seen;

   // a sent byte is the one the echo check compares against
   a_send_matches_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.send_valid) |-> (rsp_ff.send_byte == last_sent_ff))
      else $error("sent byte differs from echo reference");

   // stall only comes from a full input register
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");

   // shutdown drive and seen flag are never set together
   a_shutdown_state: assert property (@(posedge clock) disable iff (reset)
      !(sd_ff[SD_STARTED_BIT] && sd_ff[SD_SEEN_BIT]))
      else $error("shutdown started and seen at once");

   // a processed item always shows up as a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed item produced no result");

endmodule
